@@ rtl/mdcf_pkg.sv @@
// Shared constants, command kind codes and the saturation helper for the
// motor drive command framer. No dependencies.
`default_nettype none

package mdcf_pkg;

	// Frame geometry
	localparam int unsigned FrameBytes = 10;
	localparam int unsigned FrameBits  = FrameBytes * 8;
	localparam logic [3:0]  FrameLen   = 4'd10;

	// Fixed frame bytes
	localparam logic [7:0] HdrByte = 8'h48;
	localparam logic [7:0] PadByte = 8'h55;

	// Saturation limits
	localparam logic signed [15:0] PwmLim = 16'sd5000;
	localparam logic signed [15:0] CurLim = 16'sd1600;
	localparam logic signed [15:0] VelLim = 16'sd2000;

	// Command kinds
	localparam logic [3:0] KIND_RESET       = 4'd0;
	localparam logic [3:0] KIND_MODE        = 4'd1;
	localparam logic [3:0] KIND_PWM         = 4'd2;
	localparam logic [3:0] KIND_PWM_CUR     = 4'd3;
	localparam logic [3:0] KIND_PWM_VEL     = 4'd4;
	localparam logic [3:0] KIND_PWM_POS     = 4'd5;
	localparam logic [3:0] KIND_PWM_VEL_POS = 4'd6;
	localparam logic [3:0] KIND_CUR_VEL     = 4'd7;
	localparam logic [3:0] KIND_CUR_POS     = 4'd8;
	localparam logic [3:0] KIND_CUR_VEL_POS = 4'd9;

	// Clamp to +-lim, then optionally fold to the magnitude
	function automatic logic [15:0] sat_val(
		input logic signed [15:0] v,
		input logic signed [15:0] lim,
		input logic               make_abs
	);
		logic signed [15:0] s;
		s = v;
		if (v > lim) begin
			s = lim;
		end else if (v < -lim) begin
			s = -lim;
		end
		if (make_abs && (s < 16'sd0)) begin
			s = -s;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

@@ rtl/mdcf_build.sv @@
// Frame builder: saturates the command values and packs the ten-byte frame.
// Depends on mdcf_pkg.
`default_nettype none

module mdcf_build (
	input  wire logic [3:0]                     req_type,
	input  wire logic [7:0]                     drive_id,
	input  wire logic [7:0]                     mode_code,
	input  wire logic signed [15:0]             pwm_value,
	input  wire logic signed [15:0]             current_value,
	input  wire logic signed [15:0]             velocity_value,
	input  wire logic signed [31:0]             position_value,
	output logic [mdcf_pkg::FrameBits-1:0]      frame,
	output logic                                kind_ok
);

	logic [15:0] word_a;
	logic [15:0] word_b;
	logic        use_a;
	logic        use_b;
	logic        use_pos;
	logic        use_mode;

	// Select the payload words for each kind
	always_comb begin
		word_a   = 16'h0000;
		word_b   = 16'h0000;
		use_a    = 1'b0;
		use_b    = 1'b0;
		use_pos  = 1'b0;
		use_mode = 1'b0;
		kind_ok  = 1'b1;
		case (req_type)
			mdcf_pkg::KIND_RESET: begin
			end
			mdcf_pkg::KIND_MODE: begin
				use_mode = 1'b1;
			end
			mdcf_pkg::KIND_PWM: begin
				word_a = mdcf_pkg::sat_val(pwm_value, mdcf_pkg::PwmLim, 1'b0);
				use_a  = 1'b1;
			end
			mdcf_pkg::KIND_PWM_CUR: begin
				word_a = mdcf_pkg::sat_val(pwm_value, mdcf_pkg::PwmLim, 1'b1);
				word_b = mdcf_pkg::sat_val(current_value, mdcf_pkg::CurLim, 1'b0);
				use_a  = 1'b1;
				use_b  = 1'b1;
			end
			mdcf_pkg::KIND_PWM_VEL: begin
				word_a = mdcf_pkg::sat_val(pwm_value, mdcf_pkg::PwmLim, 1'b1);
				word_b = mdcf_pkg::sat_val(velocity_value, mdcf_pkg::VelLim, 1'b0);
				use_a  = 1'b1;
				use_b  = 1'b1;
			end
			mdcf_pkg::KIND_PWM_POS: begin
				word_a  = mdcf_pkg::sat_val(pwm_value, mdcf_pkg::PwmLim, 1'b1);
				use_a   = 1'b1;
				use_pos = 1'b1;
			end
			mdcf_pkg::KIND_PWM_VEL_POS: begin
				word_a  = mdcf_pkg::sat_val(pwm_value, mdcf_pkg::PwmLim, 1'b1);
				word_b  = mdcf_pkg::sat_val(velocity_value, mdcf_pkg::VelLim, 1'b1);
				use_a   = 1'b1;
				use_b   = 1'b1;
				use_pos = 1'b1;
			end
			mdcf_pkg::KIND_CUR_VEL: begin
				word_a = mdcf_pkg::sat_val(current_value, mdcf_pkg::CurLim, 1'b1);
				word_b = mdcf_pkg::sat_val(velocity_value, mdcf_pkg::VelLim, 1'b0);
				use_a  = 1'b1;
				use_b  = 1'b1;
			end
			mdcf_pkg::KIND_CUR_POS: begin
				word_a  = mdcf_pkg::sat_val(current_value, mdcf_pkg::CurLim, 1'b1);
				use_a   = 1'b1;
				use_pos = 1'b1;
			end
			mdcf_pkg::KIND_CUR_VEL_POS: begin
				word_a  = mdcf_pkg::sat_val(current_value, mdcf_pkg::CurLim, 1'b1);
				word_b  = mdcf_pkg::sat_val(velocity_value, mdcf_pkg::VelLim, 1'b1);
				use_a   = 1'b1;
				use_b   = 1'b1;
				use_pos = 1'b1;
			end
			default: begin
				kind_ok = 1'b0;
			end
		endcase
	end

	// Pack header, id and payload over a field of pad bytes, first byte on top
	always_comb begin
		frame        = {mdcf_pkg::FrameBytes{mdcf_pkg::PadByte}};
		frame[79:72] = mdcf_pkg::HdrByte;
		frame[71:64] = drive_id;
		if (use_mode) begin
			frame[63:56] = mode_code;
		end
		if (use_a) begin
			frame[63:48] = word_a;
		end
		if (use_b) begin
			frame[47:32] = word_b;
		end
		if (use_pos) begin
			frame[31:0] = position_value;
		end
	end

endmodule

`default_nettype wire

@@ rtl/mdcf_serializer.sv @@
// Frame register and byte serializer: holds one packed frame and sends it
// most significant byte first. Depends on mdcf_pkg.
`default_nettype none

module mdcf_serializer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           load,
	input  wire logic [mdcf_pkg::FrameBits-1:0] frame,
	output logic                                load_ready,
	output logic [7:0]                          frame_byte,
	output logic                                frame_last,
	output logic                                frame_valid,
	input  wire logic                           frame_ready
);

	logic [mdcf_pkg::FrameBits-1:0] frame_q;
	logic [3:0]                     cnt_q;
	logic                           beat;

	assign frame_valid = (cnt_q != 4'd0);
	assign beat        = frame_valid && frame_ready;
	assign frame_byte  = frame_q[mdcf_pkg::FrameBits-1 -: 8];
	assign frame_last  = (cnt_q == 4'd1);
	// Free when empty or when the final byte leaves this cycle
	assign load_ready  = (cnt_q == 4'd0) || (frame_last && frame_ready);

	// Count bytes left in the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (load) begin
			cnt_q <= mdcf_pkg::FrameLen;
		end else if (beat) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// Load a new frame, or shift the next byte up on each beat
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end else if (beat) begin
			frame_q <= {frame_q[mdcf_pkg::FrameBits-9:0], 8'h00};
		end
	end

	a_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cnt_q == mdcf_pkg::FrameLen))
		else $error("frame count not full after load");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ((cnt_q == 4'd0) || ((cnt_q == 4'd1) && frame_ready)))
		else $error("frame loaded over unsent bytes");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mdcf_pkg::FrameLen)
		else $error("byte count out of range");

	a_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(beat && !frame_last) |=> frame_valid)
		else $error("frame ended before last byte");

endmodule

`default_nettype wire

@@ rtl/motor_drive_command_framer_unit.sv @@
// Motor drive command framer, top level: command input register, frame
// builder and byte serializer. Depends on mdcf_pkg, mdcf_build, mdcf_serializer.
//
// Usage:
//   Command channel (cmd_valid/cmd_ready) takes one drive command per beat.
//   Frame channel (frame_valid/frame_ready) sends ten bytes per command:
//   0x48, drive_id, then eight payload bytes, with frame_last on the tenth.
//   A command with req_type above 9 is dropped and sends nothing.
// Path: when the serializer is free, a command goes through the command
//   register, then the frame register, before frame_valid rises with its first byte.
// Flow: the command rate is set by the byte-wide frame channel;
//   a new frame loads in the same cycle as the previous frame's last byte,
//   so bytes flow without gaps while commands keep coming.
// Stall: while frame_ready is low the current byte holds; one further
//   command waits in the command register, and cmd_ready falls after that.
// Reset: arst_n low empties both stages; no bytes are valid after reset.
`default_nettype none

module motor_drive_command_framer_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire logic [3:0]         req_type,
	input  wire logic [7:0]         drive_id,
	input  wire logic [7:0]         mode_code,
	input  wire logic signed [15:0] pwm_value,
	input  wire logic signed [15:0] current_value,
	input  wire logic signed [15:0] velocity_value,
	input  wire logic signed [31:0] position_value,
	output logic                    frame_valid,
	input  wire logic               frame_ready,
	output logic [7:0]              frame_byte,
	output logic                    frame_last
);

	logic                           valid_s1;
	logic [3:0]                     req_type_s1;
	logic [7:0]                     drive_id_s1;
	logic [7:0]                     mode_code_s1;
	logic signed [15:0]             pwm_s1;
	logic signed [15:0]             cur_s1;
	logic signed [15:0]             vel_s1;
	logic signed [31:0]             pos_s1;
	logic [mdcf_pkg::FrameBits-1:0] frame;
	logic                           kind_ok;
	logic                           load_ready;
	logic                           load;
	logic                           advance;

	// Move the held command on: into the serializer, or drop an unknown kind
	assign load      = valid_s1 && kind_ok && load_ready;
	assign advance   = valid_s1 && (!kind_ok || load_ready);
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	// Capture the command payload on each command beat
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			req_type_s1  <= req_type;
			drive_id_s1  <= drive_id;
			mode_code_s1 <= mode_code;
			pwm_s1       <= pwm_value;
			cur_s1       <= current_value;
			vel_s1       <= velocity_value;
			pos_s1       <= position_value;
		end
	end

	mdcf_build u_build (
		.req_type       (req_type_s1),
		.drive_id       (drive_id_s1),
		.mode_code      (mode_code_s1),
		.pwm_value      (pwm_s1),
		.current_value  (cur_s1),
		.velocity_value (vel_s1),
		.position_value (pos_s1),
		.frame          (frame),
		.kind_ok        (kind_ok)
	);

	mdcf_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.frame       (frame),
		.load_ready  (load_ready),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready)
	);

endmodule

`default_nettype wire

@@ tb/motor_drive_command_framer_unit_tb.sv @@
// Testbench for motor_drive_command_framer_unit: drives drive commands, predicts each
// ten-byte frame and checks every frame beat in order. Depends on mdcf_pkg and the RTL.
`default_nettype none

module motor_drive_command_framer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]         kind;
		logic [7:0]         id;
		logic [7:0]         mode;
		logic signed [15:0] pwm;
		logic signed [15:0] cur;
		logic signed [15:0] vel;
		logic signed [31:0] pos;
	} drive_cmd_t;

	typedef struct packed {
		drive_cmd_t  cmd;
		logic        typed;
		logic [79:0] frame;
	} cmd_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_PATTERN,
		READY_LONG_STALL
	} ready_mode_t;

	localparam int RandomFrames = 222;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	logic [3:0]         req_type = '0;
	logic [7:0]         drive_id = '0;
	logic [7:0]         mode_code = '0;
	logic signed [15:0] pwm_value = '0;
	logic signed [15:0] current_value = '0;
	logic signed [15:0] velocity_value = '0;
	logic signed [31:0] position_value = '0;
	logic               frame_valid;
	logic               frame_ready = 1'b0;
	logic [7:0]         frame_byte;
	logic               frame_last;

	frame_beat_t frame_q[$];
	int          mismatch_count = 0;
	int          burst_left = 0;
	logic [7:0]  stall_ctr = '0;
	ready_mode_t ready_mode = READY_ALWAYS;

	motor_drive_command_framer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.req_type       (req_type),
		.drive_id       (drive_id),
		.mode_code      (mode_code),
		.pwm_value      (pwm_value),
		.current_value  (current_value),
		.velocity_value (velocity_value),
		.position_value (position_value),
		.frame_valid    (frame_valid),
		.frame_ready    (frame_ready),
		.frame_byte     (frame_byte),
		.frame_last     (frame_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Clamp to +-lim, then fold to the magnitude when asked
	function automatic logic [15:0] limit_word(
		input logic signed [15:0] v,
		input logic signed [15:0] lim,
		input bit                 fold
	);
		int s;
		int l;
		s = v;
		l = lim;
		if (s > l) begin
			s = l;
		end else if (s < -l) begin
			s = -l;
		end
		if (fold && s < 0) begin
			s = -s;
		end
		return s[15:0];
	endfunction

	function automatic bit is_framed(input logic [3:0] kind);
		return kind <= mdcf_pkg::KIND_CUR_VEL_POS;
	endfunction

	// Build the ten frame bytes, byte 0 in the top bits
	function automatic logic [79:0] frame_for(input drive_cmd_t c);
		logic [15:0] lead;
		logic [15:0] mid;
		logic [31:0] tail;
		lead = {mdcf_pkg::PadByte, mdcf_pkg::PadByte};
		mid  = {mdcf_pkg::PadByte, mdcf_pkg::PadByte};
		tail = {mdcf_pkg::PadByte, mdcf_pkg::PadByte, mdcf_pkg::PadByte, mdcf_pkg::PadByte};
		case (c.kind)
			mdcf_pkg::KIND_MODE: begin
				lead = {c.mode, mdcf_pkg::PadByte};
			end
			mdcf_pkg::KIND_PWM: begin
				lead = limit_word(c.pwm, mdcf_pkg::PwmLim, 1'b0);
			end
			mdcf_pkg::KIND_PWM_CUR: begin
				lead = limit_word(c.pwm, mdcf_pkg::PwmLim, 1'b1);
				mid  = limit_word(c.cur, mdcf_pkg::CurLim, 1'b0);
			end
			mdcf_pkg::KIND_PWM_VEL: begin
				lead = limit_word(c.pwm, mdcf_pkg::PwmLim, 1'b1);
				mid  = limit_word(c.vel, mdcf_pkg::VelLim, 1'b0);
			end
			mdcf_pkg::KIND_PWM_POS: begin
				lead = limit_word(c.pwm, mdcf_pkg::PwmLim, 1'b1);
				tail = c.pos;
			end
			mdcf_pkg::KIND_PWM_VEL_POS: begin
				lead = limit_word(c.pwm, mdcf_pkg::PwmLim, 1'b1);
				mid  = limit_word(c.vel, mdcf_pkg::VelLim, 1'b1);
				tail = c.pos;
			end
			mdcf_pkg::KIND_CUR_VEL: begin
				lead = limit_word(c.cur, mdcf_pkg::CurLim, 1'b1);
				mid  = limit_word(c.vel, mdcf_pkg::VelLim, 1'b0);
			end
			mdcf_pkg::KIND_CUR_POS: begin
				lead = limit_word(c.cur, mdcf_pkg::CurLim, 1'b1);
				tail = c.pos;
			end
			mdcf_pkg::KIND_CUR_VEL_POS: begin
				lead = limit_word(c.cur, mdcf_pkg::CurLim, 1'b1);
				mid  = limit_word(c.vel, mdcf_pkg::VelLim, 1'b1);
				tail = c.pos;
			end
			default: begin
			end
		endcase
		return {mdcf_pkg::HdrByte, c.id, lead, mid, tail};
	endfunction

	task automatic queue_frame(input logic [79:0] f);
		frame_beat_t b;
		for (int k = 0; k < mdcf_pkg::FrameBytes; k++) begin
			b.data = f[79 - 8 * k -: 8];
			b.last = (k == mdcf_pkg::FrameBytes - 1);
			frame_q.push_back(b);
		end
	endtask

	function automatic cmd_row_t cmd_row(
		input logic [3:0]  kind,
		input logic [7:0]  id,
		input logic [7:0]  mode,
		input int          pwm,
		input int          cur,
		input int          vel,
		input logic [31:0] pos,
		input bit          typed,
		input logic [79:0] frame
	);
		cmd_row_t r;
		r.cmd.kind = kind;
		r.cmd.id   = id;
		r.cmd.mode = mode;
		r.cmd.pwm  = 16'(pwm);
		r.cmd.cur  = 16'(cur);
		r.cmd.vel  = 16'(vel);
		r.cmd.pos  = pos;
		r.typed    = typed;
		r.frame    = frame;
		return r;
	endfunction

	// Half the values at and around the limits, the rest near zero, at the extremes or anywhere
	function automatic logic [15:0] pick_level(input logic signed [15:0] lim);
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: v = lim;
			1: v = -lim;
			2: v = lim + 16'sd1;
			3: v = -lim - 16'sd1;
			4: v = 16'($urandom_range(0, 127)) - 16'd64;
			5: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Present one command beat, with a random gap between bursts
	task automatic send_command(input drive_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cmd_valid      <= 1'b1;
		req_type       <= c.kind;
		drive_id       <= c.id;
		mode_code      <= c.mode;
		pwm_value      <= c.pwm;
		current_value  <= c.cur;
		velocity_value <= c.vel;
		position_value <= c.pos;
		do @(posedge clk); while (!cmd_ready);
		burst_left--;
	endtask

	// Stall the frame channel on a pattern picked anew whenever stall_ctr[4:0] is zero
	always @(posedge clk) begin
		stall_ctr <= stall_ctr + 8'd1;
		if (stall_ctr[4:0] == 5'd0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
		end
		case (ready_mode)
			READY_ALWAYS:     frame_ready <= 1'b1;
			READY_RANDOM:     frame_ready <= ($urandom_range(0, 9) < 6);
			READY_PATTERN:    frame_ready <= (stall_ctr % 5 != 0);
			READY_LONG_STALL: frame_ready <= (stall_ctr[3:0] < 4'd4);
			default:          frame_ready <= 1'b1;
		endcase
	end

	// Check each frame beat against the oldest expected byte
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && frame_valid && frame_ready) begin
			if (frame_q.size() == 0) begin
				$display("%0t: unexpected frame beat: expected none, actual byte %02h last %0b",
					$time, frame_byte, frame_last);
				mismatch_count++;
			end else begin
				want = frame_q.pop_front();
				if (frame_byte !== want.data) begin
					$display("%0t: frame_byte expected %02h actual %02h",
						$time, want.data, frame_byte);
					mismatch_count++;
				end
				if (frame_last !== want.last) begin
					$display("%0t: frame_last expected %0b actual %0b",
						$time, want.last, frame_last);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus: reset, directed table, random commands, drain
	initial begin
		cmd_row_t   rows[$];
		drive_cmd_t c;
		int         framed_sent;

		// Header and pad only; unused fields must not leak into the frame
		rows.push_back(cmd_row(mdcf_pkg::KIND_RESET, 8'h00, 8'h00, 0, 0, 0, 32'h0, 1'b1,
			80'h4800_5555_5555_5555_5555));
		rows.push_back(cmd_row(mdcf_pkg::KIND_RESET, 8'hFF, 8'hFF, -1, -1, -1,
			32'hFFFF_FFFF, 1'b1, 80'h48FF_5555_5555_5555_5555));
		rows.push_back(cmd_row(mdcf_pkg::KIND_RESET, 8'h5A, 8'h3C, 32767, -32768, 1234,
			32'h1, 1'b0, '0));
		// Mode byte extremes
		rows.push_back(cmd_row(mdcf_pkg::KIND_MODE, 8'h12, 8'hA5, 7, 7, 7, 32'h7, 1'b1,
			80'h4812_A555_5555_5555_5555));
		rows.push_back(cmd_row(mdcf_pkg::KIND_MODE, 8'h01, 8'h00, 0, 0, 0, 32'h0, 1'b1,
			80'h4801_0055_5555_5555_5555));
		rows.push_back(cmd_row(mdcf_pkg::KIND_MODE, 8'h80, 8'hFF, 0, 0, 0, 32'h0, 1'b1,
			80'h4880_FF55_5555_5555_5555));
		// Signed pwm saturates both ways
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM, 8'h02, 8'h00, 32767, 0, 0, 32'h0, 1'b1,
			80'h4802_1388_5555_5555_5555));
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM, 8'h03, 8'h00, -32768, 0, 0, 32'h0, 1'b1,
			80'h4803_EC78_5555_5555_5555));
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM, 8'h20, 8'h00, 5000, 0, 0, 32'h0,
			1'b0, '0));
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM, 8'h21, 8'h00, -5001, 0, 0, 32'h0,
			1'b0, '0));
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM, 8'h22, 8'h00, 0, 0, 0, 32'h0,
			1'b0, '0));
		// Magnitude of pwm, signed current
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM_CUR, 8'h04, 8'h00, -32768, 32767, 0,
			32'h0, 1'b1, 80'h4804_1388_0640_5555_5555));
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM_CUR, 8'h05, 8'h00, -1, -32768, 0,
			32'h0, 1'b1, 80'h4805_0001_F9C0_5555_5555));
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM_VEL, 8'h30, 8'h00, 4999, 0, -32768,
			32'h0, 1'b0, '0));
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM_VEL, 8'h31, 8'h00, -5001, 0, 2001,
			32'h0, 1'b0, '0));
		// Raw position in big-endian order
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM_POS, 8'h06, 8'h00, 32767, 0, 0,
			32'h8000_0000, 1'b1, 80'h4806_1388_5555_8000_0000));
		rows.push_back(cmd_row(mdcf_pkg::KIND_PWM_VEL_POS, 8'h07, 8'h00, -5000, 0, -2000,
			32'hFFFF_FFFF, 1'b1, 80'h4807_1388_07D0_FFFF_FFFF));
		rows.push_back(cmd_row(mdcf_pkg::KIND_CUR_VEL, 8'h08, 8'h00, 0, -32768, 32767,
			32'h0, 1'b1, 80'h4808_0640_07D0_5555_5555));
		rows.push_back(cmd_row(mdcf_pkg::KIND_CUR_VEL, 8'h09, 8'h00, 0, 1601, -2001,
			32'h0, 1'b0, '0));
		rows.push_back(cmd_row(mdcf_pkg::KIND_CUR_POS, 8'h40, 8'h00, 0, 1600, 0,
			32'h7FFF_FFFF, 1'b0, '0));
		rows.push_back(cmd_row(mdcf_pkg::KIND_CUR_POS, 8'h41, 8'h00, 0, -1600, 0,
			32'h1234_5678, 1'b0, '0));
		rows.push_back(cmd_row(mdcf_pkg::KIND_CUR_VEL_POS, 8'h42, 8'h00, 0, -1601, 2001,
			32'h0, 1'b0, '0));
		rows.push_back(cmd_row(mdcf_pkg::KIND_CUR_VEL_POS, 8'h43, 8'h00, 0, 0, -1,
			32'hA5A5_5A5A, 1'b0, '0));
		// Unused kinds: dropped, no frame
		rows.push_back(cmd_row(4'd10, 8'h44, 8'h00, 1, 1, 1, 32'h1, 1'b0, '0));
		rows.push_back(cmd_row(4'd15, 8'hFF, 8'hFF, -1, -1, -1, 32'hFFFF_FFFF, 1'b0, '0));

		// Hold reset, release on a clock edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_command(rows[i].cmd);
			if (rows[i].typed) begin
				queue_frame(rows[i].frame);
			end else if (is_framed(rows[i].cmd.kind)) begin
				queue_frame(frame_for(rows[i].cmd));
			end
		end

		// Random commands, a few of them with unused kinds
		framed_sent = 0;
		while (framed_sent < RandomFrames) begin
			if ($urandom_range(0, 19) == 0) begin
				c.kind = 4'($urandom_range(10, 15));
			end else begin
				c.kind = 4'($urandom_range(0, 9));
			end
			c.id   = 8'($urandom);
			c.mode = 8'($urandom);
			c.pwm  = pick_level(mdcf_pkg::PwmLim);
			c.cur  = pick_level(mdcf_pkg::CurLim);
			c.vel  = pick_level(mdcf_pkg::VelLim);
			c.pos  = $urandom;
			send_command(c);
			if (is_framed(c.kind)) begin
				queue_frame(frame_for(c));
				framed_sent++;
			end
		end
		cmd_valid <= 1'b0;

		// Drain, then watch a little longer for stray beats
		while (frame_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("PASS motor_drive_command_framer_unit");
		end else begin
			$display("FAIL motor_drive_command_framer_unit");
		end
		$finish;
	end

	// End a hung run
	initial begin
		#1_000_000;
		$display("FAIL motor_drive_command_framer_unit");
		$finish;
	end

endmodule

`default_nettype wire
